@@ rtl/pfc_pkg.sv @@
package pfc_pkg;

   localparam int SQ_SIDE  = 5;
   localparam int SQ_CELLS = SQ_SIDE * SQ_SIDE;
   localparam int LETTERS  = 26;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] place_type;
   typedef logic [2:0] coord_type;
   typedef logic [2:0] cmd_type;

   localparam cmd_type CMD_CLEAR   = 3'd0;
   localparam cmd_type CMD_KEY     = 3'd1;
   localparam cmd_type CMD_FINISH  = 3'd2;
   localparam cmd_type CMD_ENCRYPT = 3'd3;
   localparam cmd_type CMD_DECRYPT = 3'd4;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = 5'd25;

   localparam place_type LAST_PLACE = place_type'(SQ_CELLS - 1);

   // sequencer to store: writes and read enables
   typedef struct packed {
      logic       clear;
      logic       place_en;
      letter_type place_letter;
      logic       look_en;
      logic       cell_en;
   } store_ctrl_type;

   typedef struct packed {
      logic       hit;
      letter_type letter;
   } key_letter_type;

   // saturate to Z, fold J into I
   function automatic letter_type clean_letter(input letter_type raw);
      letter_type v;
      v = raw;
      if (v > LETTER_Z) v = LETTER_Z;
      if (v == LETTER_J) v = LETTER_I;
      return v;
   endfunction

   // fold case, drop non-letters, fold J into I
   function automatic key_letter_type key_decode(input logic [7:0] b);
      logic [7:0]     u;
      logic [7:0]     d;
      key_letter_type r;
      u = b;
      if (b >= 8'h61 && b <= 8'h7A) u = b - 8'd32;
      d = u - 8'h41;
      r.hit = (u >= 8'h41) && (u <= 8'h5A);
      r.letter = d[4:0];
      if (r.letter == LETTER_J) r.letter = LETTER_I;
      return r;
   endfunction

   function automatic coord_type place_row(input place_type p);
      coord_type r;
      if (p >= 5'd20) r = 3'd4;
      else if (p >= 5'd15) r = 3'd3;
      else if (p >= 5'd10) r = 3'd2;
      else if (p >= 5'd5) r = 3'd1;
      else r = 3'd0;
      return r;
   endfunction

   function automatic coord_type place_col(input place_type p);
      coord_type r;
      place_type c;
      r = place_row(p);
      c = p - {r, 2'b00} - {2'b00, r};
      return c[2:0];
   endfunction

   // step of one (forward) or four (backward) around the square
   function automatic coord_type step_mod5(input coord_type c, input logic backward);
      logic [3:0] s;
      s = {1'b0, c} + (backward ? 4'd4 : 4'd1);
      if (s >= 4'd5) s = s - 4'd5;
      return s[2:0];
   endfunction

   function automatic place_type cell_index(input coord_type row, input coord_type col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

endpackage

@@ rtl/pfc_store.sv @@
module pfc_store (
   input  logic                    clock,
   input  logic                    reset,
   input  pfc_pkg::store_ctrl_type ctrl,
   input  pfc_pkg::letter_type     look_a,
   input  pfc_pkg::letter_type     look_b,
   input  pfc_pkg::place_type      cell_a,
   input  pfc_pkg::place_type      cell_b,
   output pfc_pkg::place_type      place_a_q,
   output pfc_pkg::place_type      place_b_q,
   output pfc_pkg::letter_type     cell_a_q,
   output pfc_pkg::letter_type     cell_b_q
);
   import pfc_pkg::*;

   letter_type          key_square [SQ_CELLS];
   place_type           letter_place [LETTERS];
   logic [LETTERS-1:0]  used_ff, used_in;
   place_type           fill_ff, fill_in;
   logic                do_place;

   assign do_place = ctrl.place_en && (ctrl.place_letter <= LETTER_Z)
                     && (fill_ff <= LAST_PLACE) && !used_ff[ctrl.place_letter];

   always_comb begin
      used_in = used_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         used_in = '0;
         fill_in = '0;
      end else if (do_place) begin
         used_in[ctrl.place_letter] = 1'b1;
         fill_in = fill_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_place && !ctrl.clear) begin
         key_square[fill_ff] <= ctrl.place_letter;
         letter_place[ctrl.place_letter] <= fill_ff;
      end
      if (ctrl.look_en) begin
         place_a_q <= letter_place[look_a];
         place_b_q <= letter_place[look_b];
      end
      if (ctrl.cell_en) begin
         cell_a_q <= key_square[cell_a];
         cell_b_q <= key_square[cell_b];
      end
   end

endmodule

@@ rtl/playfair_digraph_cipher.sv @@
// Channel   Direction  Ports                                              Word
// req       in         req_valid req_ready req_cmd req_key_byte           one command
//                      req_first_letter req_second_letter
// rsp       out        rsp_valid rsp_ready rsp_out_first rsp_out_second   one pair result
//                      rsp_status
//
// Clear and key byte words leave the block idle. Finish walks the alphabet one
// letter a cycle through the store's write port. An encrypt or decrypt word
// steps through place lookup, cell lookup and result load, set by the two
// registered memory reads in sequence. A stalled rsp holds the block in the
// result load step. Reset is synchronous and empties the key square.
module playfair_digraph_cipher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfc_pkg::cmd_type    req_cmd,
   input  logic [7:0]          req_key_byte,
   input  pfc_pkg::letter_type req_first_letter,
   input  pfc_pkg::letter_type req_second_letter,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfc_pkg::letter_type rsp_out_first,
   output pfc_pkg::letter_type rsp_out_second,
   output logic                rsp_status
);
   import pfc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_FILL  = 2'd3;

   logic [1:0]     state_ff, state_in;
   letter_type     walk_ff, walk_in;
   logic           ready_sq_ff, ready_sq_in;
   logic           backward_ff, backward_in;
   logic           unready_ff, unready_in;
   logic           rsp_valid_ff, rsp_valid_in;
   letter_type     rsp_first_ff, rsp_first_in;
   letter_type     rsp_second_ff, rsp_second_in;
   logic           rsp_status_ff, rsp_status_in;

   store_ctrl_type ctrl;
   key_letter_type kd;
   place_type      place_a_q, place_b_q, cell_a, cell_b;
   letter_type     cell_a_q, cell_b_q;
   coord_type      r1, c1, r2, c2;
   logic           accept;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;
   assign rsp_status     = rsp_status_ff;
   assign kd             = key_decode(req_key_byte);

   pfc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .look_a    (clean_letter(req_first_letter)),
      .look_b    (clean_letter(req_second_letter)),
      .cell_a    (cell_a),
      .cell_b    (cell_b),
      .place_a_q (place_a_q),
      .place_b_q (place_b_q),
      .cell_a_q  (cell_a_q),
      .cell_b_q  (cell_b_q)
   );

   // Locate the output cells from the two registered places.
   always_comb begin
      r1 = place_row(place_a_q);
      c1 = place_col(place_a_q);
      r2 = place_row(place_b_q);
      c2 = place_col(place_b_q);
      if (r1 == r2) begin
         cell_a = cell_index(r1, step_mod5(c1, backward_ff));
         cell_b = cell_index(r2, step_mod5(c2, backward_ff));
      end else if (c1 == c2) begin
         cell_a = cell_index(step_mod5(r1, backward_ff), c1);
         cell_b = cell_index(step_mod5(r2, backward_ff), c2);
      end else begin
         cell_a = cell_index(r1, c2);
         cell_b = cell_index(r2, c1);
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      ready_sq_in   = ready_sq_ff;
      backward_in   = backward_ff;
      unready_in    = unready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_status_in = rsp_status_ff;
      ctrl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd) inside
                  CMD_CLEAR: begin
                     ctrl.clear  = 1'b1;
                     ready_sq_in = 1'b0;
                  end
                  CMD_KEY: begin
                     ctrl.place_en     = kd.hit;
                     ctrl.place_letter = kd.letter;
                  end
                  CMD_FINISH: begin
                     walk_in  = '0;
                     state_in = ST_FILL;
                  end
                  CMD_ENCRYPT, CMD_DECRYPT: begin
                     ctrl.look_en = 1'b1;
                     backward_in  = (req_cmd == CMD_DECRYPT);
                     unready_in   = !ready_sq_ff;
                     state_in     = ST_LOOK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            ctrl.place_en     = (walk_ff != LETTER_J);
            ctrl.place_letter = walk_ff;
            if (walk_ff == LETTER_Z) begin
               ready_sq_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               walk_in = walk_ff + 5'd1;
            end
         end
         ST_LOOK: begin
            ctrl.cell_en = 1'b1;
            state_in     = ST_FETCH;
         end
         ST_FETCH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = unready_ff ? '0 : cell_a_q;
               rsp_second_in = unready_ff ? '0 : cell_b_q;
               rsp_status_in = unready_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_sq_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_sq_ff  <= ready_sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      backward_ff   <= backward_in;
      unready_ff    <= unready_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ verif/tb_playfair_digraph_cipher.sv @@
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;
   import pfc_pkg::*;

   // run shape
   localparam int TOTAL_WORDS      = 1750;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;
   localparam int MAX_REPORTS      = 40;

   // ASCII landmarks for key bytes
   localparam int CHAR_UPPER_A = 8'h41;
   localparam int CHAR_UPPER_Z = 8'h5A;
   localparam int CHAR_LOWER_A = 8'h61;
   localparam int CHAR_LOWER_Z = 8'h7A;
   localparam int CASE_OFFSET  = 32;

   localparam logic STATUS_DONE      = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   typedef struct packed {
      letter_type out_first;
      letter_type out_second;
      logic       status;
   } pair_result_type;

   // receiver stall patterns
   typedef enum int {RSP_ALWAYS, RSP_HALF, RSP_SPARSE, RSP_MOSTLY} rsp_pattern_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   cmd_type    req_cmd           = CMD_CLEAR;
   logic [7:0] req_key_byte      = 8'h00;
   letter_type req_first_letter  = 5'd0;
   letter_type req_second_letter = 5'd0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   letter_type rsp_out_first;
   letter_type rsp_out_second;
   logic       rsp_status;

   // predictor copy of the key square
   letter_type          key_sq [SQ_CELLS];
   place_type           place_of [LETTERS];
   logic [LETTERS-1:0]  letter_seen = '0;
   int                  fill_level  = 0;
   bit                  square_done = 1'b0;

   pair_result_type expected_pairs [$];

   int mismatch_count   = 0;
   int words_sent       = 0;
   int pairs_checked    = 0;
   int squares_finished = 0;
   int burst_left       = 0;

   // receiver controls
   bit              hold_request = 1'b0;
   int              hold_left    = 0;
   int              pattern_left = 0;
   rsp_pattern_type rsp_pattern  = RSP_ALWAYS;

   playfair_digraph_cipher u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key_byte      (req_key_byte),
      .req_first_letter  (req_first_letter),
      .req_second_letter (req_second_letter),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_first     (rsp_out_first),
      .rsp_out_second    (rsp_out_second),
      .rsp_status        (rsp_status)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // append a letter at the next free place, unless already used or full
   function automatic void add_to_square(int l);
      if (l > LETTER_Z || fill_level >= SQ_CELLS || letter_seen[l]) return;
      letter_seen[l]   = 1'b1;
      key_sq[fill_level] = letter_type'(l);
      place_of[l]      = place_type'(fill_level);
      fill_level++;
   endfunction

   // saturate out-of-range codes to Z, treat J as I
   function automatic letter_type fold_letter(letter_type raw);
      if (raw > LETTER_Z) return LETTER_Z;
      if (raw == LETTER_J) return LETTER_I;
      return raw;
   endfunction

   // advance the predictor by one accepted word, queue any pair result
   task automatic model_word(cmd_type cmd, logic [7:0] kb, letter_type fa, letter_type fb);
      int              ch;
      int              l;
      int              pa, pb, r1, c1, r2, c2, step;
      pair_result_type res;
      case (cmd) inside
         CMD_CLEAR: begin
            letter_seen = '0;
            fill_level  = 0;
            square_done = 1'b0;
         end
         CMD_KEY: begin
            ch = int'(kb);
            if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch -= CASE_OFFSET;
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
               l = ch - CHAR_UPPER_A;
               if (l == LETTER_J) l = LETTER_I;
               add_to_square(l);
            end
         end
         CMD_FINISH: begin
            for (l = 0; l <= LETTER_Z; l++) begin
               if (l != LETTER_J) add_to_square(l);
            end
            square_done = 1'b1;
            squares_finished++;
         end
         CMD_ENCRYPT, CMD_DECRYPT: begin
            if (!square_done) begin
               res = '{out_first: 5'd0, out_second: 5'd0, status: STATUS_NOT_READY};
            end else begin
               pa   = int'(place_of[fold_letter(fa)]);
               pb   = int'(place_of[fold_letter(fb)]);
               r1   = pa / SQ_SIDE;
               c1   = pa % SQ_SIDE;
               r2   = pb / SQ_SIDE;
               c2   = pb % SQ_SIDE;
               step = (cmd == CMD_ENCRYPT) ? 1 : SQ_SIDE - 1;
               res.status = STATUS_DONE;
               if (r1 == r2) begin
                  res.out_first  = key_sq[r1 * SQ_SIDE + (c1 + step) % SQ_SIDE];
                  res.out_second = key_sq[r2 * SQ_SIDE + (c2 + step) % SQ_SIDE];
               end else if (c1 == c2) begin
                  res.out_first  = key_sq[((r1 + step) % SQ_SIDE) * SQ_SIDE + c1];
                  res.out_second = key_sq[((r2 + step) % SQ_SIDE) * SQ_SIDE + c2];
               end else begin
                  res.out_first  = key_sq[r1 * SQ_SIDE + c2];
                  res.out_second = key_sq[r2 * SQ_SIDE + c1];
               end
            end
            expected_pairs.push_back(res);
         end
         default: begin
            // unused codes: no state change, no result
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic letter_type any_letter_code();
      return letter_type'($urandom_range(0, 31));
   endfunction

   function automatic cmd_type pick_cipher_cmd();
      return ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
   endfunction

   // mostly letters of either case, some raw noise bytes
   function automatic logic [7:0] pick_key_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 8'(CHAR_UPPER_A + $urandom_range(0, 25));
      if (r < 8) return 8'(CHAR_LOWER_A + $urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   // Send one word. Bursts of random length, random idle gaps between them;
   // the predictor advances at the edge the word is taken.
   task automatic send_word(cmd_type cmd, logic [7:0] kb, letter_type fa, letter_type fb);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_valid         <= 1'b0;
            req_cmd           <= cmd_type'($urandom_range(0, 7));
            req_key_byte      <= 8'($urandom_range(0, 255));
            req_first_letter  <= any_letter_code();
            req_second_letter <= any_letter_code();
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_key_byte      <= kb;
      req_first_letter  <= fa;
      req_second_letter <= fb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_word(cmd, kb, fa, fb);
      words_sent++;
   endtask

   task automatic send_key_byte(logic [7:0] kb);
      send_word(CMD_KEY, kb, any_letter_code(), any_letter_code());
   endtask

   // drop valid and hold until every queued pair result has been checked
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
   endtask

   // Pairs aimed at the square: same row, same column, any two places,
   // or raw codes. Occasionally swap I for J.
   task automatic pick_pair(output letter_type fa, output letter_type fb);
      int shape, row, col;
      if (!square_done) begin
         fa = any_letter_code();
         fb = any_letter_code();
         return;
      end
      shape = $urandom_range(0, 9);
      if (shape < 3) begin
         row = $urandom_range(0, SQ_SIDE - 1);
         fa  = key_sq[row * SQ_SIDE + $urandom_range(0, SQ_SIDE - 1)];
         fb  = key_sq[row * SQ_SIDE + $urandom_range(0, SQ_SIDE - 1)];
      end else if (shape < 6) begin
         col = $urandom_range(0, SQ_SIDE - 1);
         fa  = key_sq[$urandom_range(0, SQ_SIDE - 1) * SQ_SIDE + col];
         fb  = key_sq[$urandom_range(0, SQ_SIDE - 1) * SQ_SIDE + col];
      end else if (shape == 6) begin
         fa = any_letter_code();
         fb = any_letter_code();
      end else begin
         fa = key_sq[$urandom_range(0, SQ_CELLS - 1)];
         fb = key_sq[$urandom_range(0, SQ_CELLS - 1)];
      end
      if (fa == LETTER_I && $urandom_range(0, 1) == 0) fa = LETTER_J;
      if (fb == LETTER_I && $urandom_range(0, 1) == 0) fb = LETTER_J;
   endtask

   // key holding the whole alphabet in random order: fills the square
   // before finish, so the extra bytes hit a full square
   task automatic send_alphabet_key();
      int order [LETTERS];
      int i, j, t;
      for (i = 0; i < LETTERS; i++) order[i] = i;
      for (i = LETTERS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < LETTERS; i++) begin
         if ($urandom_range(0, 1) == 0) send_key_byte(8'(CHAR_UPPER_A + order[i]));
         else send_key_byte(8'(CHAR_LOWER_A + order[i]));
      end
      repeat ($urandom_range(1, 4)) send_key_byte(pick_key_byte());
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // pairs before any square is built must come back flagged
   task automatic test_unkeyed_pairs();
      send_word(CMD_ENCRYPT, 8'h00, 5'd0, LETTER_Z);
      send_word(CMD_DECRYPT, 8'hFF, 5'd31, LETTER_J);
      wait_for_results();
   endtask

   // case folding, J to I, duplicates, non-letters at every boundary,
   // pair on a half-built square, repeated finish, key byte after finish
   task automatic test_key_and_finish();
      send_key_byte(8'h70);
      send_key_byte(8'h4C);
      send_key_byte(8'h61);
      send_key_byte(8'h59);
      send_key_byte(8'h6A);
      send_key_byte(8'h69);
      send_key_byte(8'h40);
      send_key_byte(8'h5B);
      send_key_byte(8'h60);
      send_key_byte(8'h7B);
      send_key_byte(8'hFF);
      send_key_byte(8'h00);
      send_word(CMD_ENCRYPT, 8'h00, 5'd15, 5'd11);
      send_word(CMD_FINISH, 8'hFF, any_letter_code(), any_letter_code());
      send_word(CMD_FINISH, 8'h00, any_letter_code(), any_letter_code());
      send_key_byte(8'h51);
      wait_for_results();
   endtask

   // row and column rules both ways, the rectangle, wrap-around, equal letters,
   // J and codes above Z, then the unused command codes
   task automatic test_cipher_rules();
      send_word(CMD_ENCRYPT, 8'h00, key_sq[0], key_sq[4]);
      send_word(CMD_ENCRYPT, 8'h00, key_sq[1], key_sq[21]);
      send_word(CMD_ENCRYPT, 8'h00, key_sq[6], key_sq[18]);
      send_word(CMD_ENCRYPT, 8'h00, key_sq[12], key_sq[12]);
      send_word(CMD_ENCRYPT, 8'h00, LETTER_J, 5'd31);
      send_word(CMD_DECRYPT, 8'hFF, key_sq[4], key_sq[0]);
      send_word(CMD_DECRYPT, 8'hFF, key_sq[20], key_sq[5]);
      send_word(cmd_type'(5), 8'hFF, 5'd31, 5'd31);
      send_word(cmd_type'(6), 8'h00, 5'd0, 5'd0);
      send_word(cmd_type'(7), 8'hA5, 5'd26, 5'd27);
      wait_for_results();
   endtask

   // hold the receiver off for a long stretch while pairs keep coming,
   // so the block fills and stalls its input; then drain completely
   task automatic test_input_backpressure();
      letter_type fa, fb;
      hold_request = 1'b1;
      repeat (30) begin
         pick_pair(fa, fb);
         send_word(pick_cipher_cmd(), 8'($urandom_range(0, 255)), fa, fb);
      end
      wait_for_results();
   endtask

   // one key session: optional clear, key of random length and shape,
   // usually a finish, then a run of pairs with the odd stray word
   task automatic run_session();
      int         key_len, pair_count, shape, i;
      letter_type fa, fb;
      if ($urandom_range(0, 9) != 0)
         send_word(CMD_CLEAR, 8'($urandom_range(0, 255)), any_letter_code(), any_letter_code());
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         send_alphabet_key();
      end else begin
         key_len = $urandom_range(0, (shape < 4) ? 6 : 30);
         for (i = 0; i < key_len; i++) begin
            // stray pair while the key is being sent
            if ($urandom_range(0, 19) == 0) begin
               pick_pair(fa, fb);
               send_word(pick_cipher_cmd(), 8'($urandom_range(0, 255)), fa, fb);
            end
            send_key_byte(pick_key_byte());
         end
      end
      if ($urandom_range(0, 9) != 0)
         send_word(CMD_FINISH, 8'($urandom_range(0, 255)), any_letter_code(), any_letter_code());
      if ($urandom_range(0, 4) == 0) send_key_byte(pick_key_byte());
      if ($urandom_range(0, 9) == 0)
         send_word(CMD_FINISH, 8'($urandom_range(0, 255)), any_letter_code(), any_letter_code());
      pair_count = $urandom_range(4, 40);
      for (i = 0; i < pair_count; i++) begin
         if ($urandom_range(0, 24) == 0) begin
            send_word(cmd_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      any_letter_code(), any_letter_code());
         end else begin
            pick_pair(fa, fb);
            send_word(pick_cipher_cmd(), 8'($urandom_range(0, 255)), fa, fb);
         end
      end
   endtask

   task automatic test_random_sessions();
      while (words_sent < TOTAL_WORDS) run_session();
      wait_for_results();
   endtask

   // ------------------------------------------------------------------
   // Receiver and checker
   // ------------------------------------------------------------------

   // Stall on a randomly chosen pattern, picked anew when its run ends; a requested
   // long hold takes over and counts itself down here.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rsp_pattern  = rsp_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(8, 80);
         end
         pattern_left--;
         case (rsp_pattern)
            RSP_ALWAYS: rsp_ready <= 1'b1;
            RSP_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            RSP_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // compare every taken result against the oldest queued one
   always @(posedge clock) begin : check_results
      pair_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            report_mismatch($sformatf("pair result %0d/%0d status %0d with none pending",
                                      rsp_out_first, rsp_out_second, rsp_status));
         end else begin
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (rsp_out_first !== want.out_first || rsp_out_second !== want.out_second ||
                rsp_status !== want.status)
               report_mismatch($sformatf("pair got %0d/%0d status %0d, want %0d/%0d status %0d",
                                         rsp_out_first, rsp_out_second, rsp_status,
                                         want.out_first, want.out_second, want.status));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unkeyed_pairs();
      test_key_and_finish();
      test_cipher_rules();
      test_input_backpressure();
      test_random_sessions();

      // let any stray result show up before deciding
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d command words, checked %0d pair results over %0d finished squares",
               words_sent, pairs_checked, squares_finished);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #2000000;
      $display("Timed out with %0d pair results still pending", expected_pairs.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pfc_pkg.sv
rtl/pfc_store.sv
rtl/playfair_digraph_cipher.sv
verif/tb_playfair_digraph_cipher.sv
